// ===== rtl/rti_pkg.sv =====
// shared widths, register indexes, payload types and helpers of the ray/triangle test
package rti_pkg;

    localparam int CW    = 20;
    localparam int FB    = 10;
    localparam int TW    = CW + 1;
    localparam int PW    = 2 * CW + 1;
    localparam int QW    = 2 * CW + 2;
    localparam int SW    = 3 * CW + 6;
    localparam int DW    = SW + CW + 1;
    localparam int CFG_W = 3 * CW;
    localparam int OBJ_W = 16;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_VERTEX0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_EDGE1   = 3'd1;
    localparam logic [IDX_W-1:0] REG_EDGE2   = 3'd2;
    localparam logic [IDX_W-1:0] REG_NORMAL  = 3'd3;
    localparam logic [IDX_W-1:0] REG_OBJECT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_EPSILON = 3'd5;
    localparam logic [IDX_W-1:0] REG_CULL    = 3'd6;

    localparam logic signed [PW+1:0] COORD_MAX = (PW+2)'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [PW+1:0] COORD_MIN = -COORD_MAX - (PW+2)'(1);

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t origin_x;
        coord_t origin_y;
        coord_t origin_z;
        coord_t direction_x;
        coord_t direction_y;
        coord_t direction_z;
    } rti_in_t;

    typedef struct packed {
        logic             hit;
        logic [CW-1:0]    distance;
        coord_t           hit_x;
        coord_t           hit_y;
        coord_t           hit_z;
        coord_t           surface_nx;
        coord_t           surface_ny;
        coord_t           surface_nz;
        logic [OBJ_W-1:0] hit_object;
    } rti_out_t;

    typedef struct packed {
        rti_in_t       ray;
        logic          miss;
        logic          tneg;
        logic          sat;
        logic [SW-1:0] det;
        logic [SW-1:0] tnm;
    } rti_front_t;

    function automatic coord_t vec_elem(input logic [CFG_W-1:0] p, input int k);
        return coord_t'(p[k*CW +: CW]);
    endfunction

    function automatic coord_t hit_coord(input logic signed [PW-1:0] p, input coord_t o);
        logic [PW-1:0]          mag;
        logic signed [PW+1:0]   s;
        logic signed [PW+1:0]   v;
        mag = p[PW-1] ? $unsigned(-p) : $unsigned(p);
        mag = mag >> FB;
        s = p[PW-1] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        v = (PW+2)'(o) + s;
        if (v > COORD_MAX) begin
            return coord_t'(COORD_MAX);
        end else if (v < COORD_MIN) begin
            return coord_t'(COORD_MIN);
        end
        return coord_t'(v);
    endfunction

endpackage

// ===== rtl/rti_front.sv =====
// front pipeline: cross and dot products, determinant, bounds and sign handling
module rti_front import rti_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  rti_in_t          in_ray,
    input  logic [CFG_W-1:0] vertex0,
    input  logic [CFG_W-1:0] edge1,
    input  logic [CFG_W-1:0] edge2,
    input  logic [CW-1:0]    epsilon,
    input  logic             cull,
    output logic             out_valid,
    output rti_front_t       out_data
);

    // wide operands are split at LO into a signed high and an unsigned low half
    localparam int LO = CW + 1;
    localparam int MW = 2 * CW + 4;

    coord_t e1 [3];
    coord_t e2 [3];
    coord_t v0 [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e1[k] = vec_elem(edge1, k);
            e2[k] = vec_elem(edge2, k);
            v0[k] = vec_elem(vertex0, k);
        end
    end

    // stage a
    logic                     a_v_reg;
    rti_in_t                  a_ray_reg;
    logic signed [TW-1:0]     a_tv_reg [3];
    logic signed [TW-1:0]     a_tv_next [3];
    logic signed [2*CW-1:0]   a_pp_reg [6];
    logic signed [2*CW-1:0]   a_pp_next [6];

    always_comb begin
        a_tv_next[0] = TW'(in_ray.origin_x) - TW'(v0[0]);
        a_tv_next[1] = TW'(in_ray.origin_y) - TW'(v0[1]);
        a_tv_next[2] = TW'(in_ray.origin_z) - TW'(v0[2]);
        a_pp_next[0] = (2*CW)'(in_ray.direction_y) * (2*CW)'(e2[2]);
        a_pp_next[1] = (2*CW)'(in_ray.direction_z) * (2*CW)'(e2[1]);
        a_pp_next[2] = (2*CW)'(in_ray.direction_z) * (2*CW)'(e2[0]);
        a_pp_next[3] = (2*CW)'(in_ray.direction_x) * (2*CW)'(e2[2]);
        a_pp_next[4] = (2*CW)'(in_ray.direction_x) * (2*CW)'(e2[1]);
        a_pp_next[5] = (2*CW)'(in_ray.direction_y) * (2*CW)'(e2[0]);
    end

    // stage b
    logic                     b_v_reg;
    rti_in_t                  b_ray_reg;
    logic signed [TW-1:0]     b_tv_reg [3];
    logic signed [PW-1:0]     b_pv_reg [3];
    logic signed [PW-1:0]     b_pv_next [3];
    logic signed [TW+CW-1:0]  b_qp_reg [6];
    logic signed [TW+CW-1:0]  b_qp_next [6];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            b_pv_next[k] = PW'(a_pp_reg[2*k]) - PW'(a_pp_reg[2*k+1]);
        end
        b_qp_next[0] = (TW+CW)'(a_tv_reg[1]) * (TW+CW)'(e1[2]);
        b_qp_next[1] = (TW+CW)'(a_tv_reg[2]) * (TW+CW)'(e1[1]);
        b_qp_next[2] = (TW+CW)'(a_tv_reg[2]) * (TW+CW)'(e1[0]);
        b_qp_next[3] = (TW+CW)'(a_tv_reg[0]) * (TW+CW)'(e1[2]);
        b_qp_next[4] = (TW+CW)'(a_tv_reg[0]) * (TW+CW)'(e1[1]);
        b_qp_next[5] = (TW+CW)'(a_tv_reg[1]) * (TW+CW)'(e1[0]);
    end

    // stage c
    logic                 c_v_reg;
    rti_in_t              c_ray_reg;
    logic signed [QW-1:0] c_qv_reg [3];
    logic signed [QW-1:0] c_qv_next [3];
    logic signed [CW-1:0] pv_hi [3];
    logic signed [LO:0]   pv_lo [3];
    logic signed [MW-1:0] c_dhi_reg [3];
    logic signed [MW-1:0] c_dhi_next [3];
    logic signed [MW-1:0] c_dlo_reg [3];
    logic signed [MW-1:0] c_dlo_next [3];
    logic signed [MW-1:0] c_uhi_reg [3];
    logic signed [MW-1:0] c_uhi_next [3];
    logic signed [MW-1:0] c_ulo_reg [3];
    logic signed [MW-1:0] c_ulo_next [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c_qv_next[k]  = QW'(b_qp_reg[2*k]) - QW'(b_qp_reg[2*k+1]);
            pv_hi[k]      = b_pv_reg[k][PW-1:LO];
            pv_lo[k]      = $signed({1'b0, b_pv_reg[k][LO-1:0]});
            c_dhi_next[k] = MW'(e1[k]) * MW'(pv_hi[k]);
            c_dlo_next[k] = MW'(e1[k]) * MW'(pv_lo[k]);
            c_uhi_next[k] = MW'(b_tv_reg[k]) * MW'(pv_hi[k]);
            c_ulo_next[k] = MW'(b_tv_reg[k]) * MW'(pv_lo[k]);
        end
    end

    // stage d
    logic                 d_v_reg;
    rti_in_t              d_ray_reg;
    logic signed [SW-1:0] d_det_reg;
    logic signed [SW-1:0] d_det_next;
    logic signed [SW-1:0] d_un_reg;
    logic signed [SW-1:0] d_un_next;
    logic signed [LO-1:0] qv_hi [3];
    logic signed [LO:0]   qv_lo [3];
    logic signed [MW-1:0] d_vhi_reg [3];
    logic signed [MW-1:0] d_vhi_next [3];
    logic signed [MW-1:0] d_vlo_reg [3];
    logic signed [MW-1:0] d_vlo_next [3];
    logic signed [MW-1:0] d_thi_reg [3];
    logic signed [MW-1:0] d_thi_next [3];
    logic signed [MW-1:0] d_tlo_reg [3];
    logic signed [MW-1:0] d_tlo_next [3];
    coord_t               cd [3];

    always_comb begin
        cd[0] = c_ray_reg.direction_x;
        cd[1] = c_ray_reg.direction_y;
        cd[2] = c_ray_reg.direction_z;
        d_det_next = '0;
        d_un_next  = '0;
        for (int k = 0; k < 3; k++) begin
            d_det_next = d_det_next + (SW'(c_dhi_reg[k]) <<< LO) + SW'(c_dlo_reg[k]);
            d_un_next  = d_un_next + (SW'(c_uhi_reg[k]) <<< LO) + SW'(c_ulo_reg[k]);
            qv_hi[k]      = c_qv_reg[k][QW-1:LO];
            qv_lo[k]      = $signed({1'b0, c_qv_reg[k][LO-1:0]});
            d_vhi_next[k] = MW'(cd[k]) * MW'(qv_hi[k]);
            d_vlo_next[k] = MW'(cd[k]) * MW'(qv_lo[k]);
            d_thi_next[k] = MW'(e2[k]) * MW'(qv_hi[k]);
            d_tlo_next[k] = MW'(e2[k]) * MW'(qv_lo[k]);
        end
    end

    // stage e
    logic                 e_v_reg;
    rti_in_t              e_ray_reg;
    logic signed [SW-1:0] e_det_reg;
    logic signed [SW-1:0] e_un_reg;
    logic signed [SW-1:0] e_vn_reg;
    logic signed [SW-1:0] e_vn_next;
    logic signed [SW-1:0] e_tn_reg;
    logic signed [SW-1:0] e_tn_next;
    logic                 e_miss_reg;
    logic                 e_miss_next;
    logic signed [SW-1:0] thr;
    logic signed [SW-1:0] abs_det;

    always_comb begin
        e_vn_next = '0;
        e_tn_next = '0;
        for (int k = 0; k < 3; k++) begin
            e_vn_next = e_vn_next + (SW'(d_vhi_reg[k]) <<< LO) + SW'(d_vlo_reg[k]);
            e_tn_next = e_tn_next + (SW'(d_thi_reg[k]) <<< LO) + SW'(d_tlo_reg[k]);
        end
        thr       = SW'(epsilon) << (2 * FB);
        abs_det   = d_det_reg[SW-1] ? -d_det_reg : d_det_reg;
        e_miss_next = (d_det_reg == '0) || (cull ? (d_det_reg < thr) : (abs_det < thr));
    end

    // stage f
    logic                 f_v_reg;
    rti_in_t              f_ray_reg;
    logic signed [SW-1:0] f_det_reg;
    logic signed [SW-1:0] f_det_next;
    logic signed [SW-1:0] f_un_reg;
    logic signed [SW-1:0] f_un_next;
    logic signed [SW-1:0] f_vn_reg;
    logic signed [SW-1:0] f_vn_next;
    logic signed [SW-1:0] f_tn_reg;
    logic signed [SW-1:0] f_tn_next;
    logic                 f_miss_reg;

    always_comb begin
        if (e_det_reg[SW-1]) begin
            f_det_next = -e_det_reg;
            f_un_next  = -e_un_reg;
            f_vn_next  = -e_vn_reg;
            f_tn_next  = -e_tn_reg;
        end else begin
            f_det_next = e_det_reg;
            f_un_next  = e_un_reg;
            f_vn_next  = e_vn_reg;
            f_tn_next  = e_tn_reg;
        end
    end

    // stage g
    logic                 g_v_reg;
    rti_front_t           g_reg;
    rti_front_t           g_next;
    logic signed [SW-1:0] uv_sum;

    always_comb begin
        uv_sum      = f_un_reg + f_vn_reg;
        g_next.ray  = f_ray_reg;
        g_next.tneg = f_tn_reg[SW-1];
        g_next.det  = $unsigned(f_det_reg);
        g_next.tnm  = f_tn_reg[SW-1] ? $unsigned(-f_tn_reg) : $unsigned(f_tn_reg);
        g_next.miss = f_miss_reg || f_un_reg[SW-1] || (f_det_reg < f_un_reg) ||
                      f_vn_reg[SW-1] || (f_det_reg < uv_sum);
        g_next.sat  = DW'(g_next.tnm) >= (DW'(g_next.det) << (CW - FB));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
            f_v_reg <= e_v_reg;
            g_v_reg <= f_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_ray_reg  <= in_ray;
            a_tv_reg   <= a_tv_next;
            a_pp_reg   <= a_pp_next;
            b_ray_reg  <= a_ray_reg;
            b_tv_reg   <= a_tv_reg;
            b_pv_reg   <= b_pv_next;
            b_qp_reg   <= b_qp_next;
            c_ray_reg  <= b_ray_reg;
            c_qv_reg   <= c_qv_next;
            c_dhi_reg  <= c_dhi_next;
            c_dlo_reg  <= c_dlo_next;
            c_uhi_reg  <= c_uhi_next;
            c_ulo_reg  <= c_ulo_next;
            d_ray_reg  <= c_ray_reg;
            d_det_reg  <= d_det_next;
            d_un_reg   <= d_un_next;
            d_vhi_reg  <= d_vhi_next;
            d_vlo_reg  <= d_vlo_next;
            d_thi_reg  <= d_thi_next;
            d_tlo_reg  <= d_tlo_next;
            e_ray_reg  <= d_ray_reg;
            e_det_reg  <= d_det_reg;
            e_un_reg   <= d_un_reg;
            e_vn_reg   <= e_vn_next;
            e_tn_reg   <= e_tn_next;
            e_miss_reg <= e_miss_next;
            f_ray_reg  <= e_ray_reg;
            f_det_reg  <= f_det_next;
            f_un_reg   <= f_un_next;
            f_vn_reg   <= f_vn_next;
            f_tn_reg   <= f_tn_next;
            f_miss_reg <= e_miss_reg;
            g_reg      <= g_next;
        end
    end

    assign out_valid = g_v_reg;
    assign out_data  = g_reg;

endmodule

// ===== rtl/rti_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module rti_div import rti_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    input  rti_front_t in_data,
    output logic       out_valid,
    output rti_front_t out_data,
    output logic [CW-1:0] out_q
);

    logic             st_v   [CW+1];
    rti_front_t       st_c   [CW+1];
    logic [DW-1:0]    st_rem [CW+1];
    logic [CW-1:0]    st_q   [CW+1];

    assign st_v[0]   = in_valid;
    assign st_c[0]   = in_data;
    assign st_rem[0] = DW'(in_data.tnm) << FB;
    assign st_q[0]   = '0;

    for (genvar j = 0; j < CW; j++) begin : g_stage
        localparam int BIT = CW - 1 - j;
        logic [DW-1:0] dsh;
        logic [DW-1:0] rem_next;
        logic [CW-1:0] q_next;

        always_comb begin
            dsh      = DW'(st_c[j].det) << BIT;
            rem_next = st_rem[j];
            q_next   = st_q[j];
            if (st_rem[j] >= dsh) begin
                rem_next    = st_rem[j] - dsh;
                q_next[BIT] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_v[j+1] <= 1'b0;
            end else if (en) begin
                st_v[j+1] <= st_v[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_c[j+1]   <= st_c[j];
                st_rem[j+1] <= rem_next;
                st_q[j+1]   <= q_next;
            end
        end
    end

    assign out_valid = st_v[CW];
    assign out_data  = st_c[CW];
    assign out_q     = st_q[CW];

endmodule

// ===== rtl/rti_back.sv =====
// back pipeline: distance select, epsilon test, hit point and result register
module rti_back import rti_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  rti_front_t       in_data,
    input  logic [CW-1:0]    in_q,
    input  logic [CW-1:0]    epsilon,
    input  logic [CFG_W-1:0] normal,
    input  logic [OBJ_W-1:0] object_id,
    output logic             out_valid,
    output rti_out_t         out_data
);

    logic                 h_v_reg;
    logic                 h_miss_reg;
    logic                 h_miss_next;
    logic [CW-1:0]        h_t_reg;
    logic [CW-1:0]        h_t_next;
    logic signed [PW-1:0] h_p_reg [3];
    logic signed [PW-1:0] h_p_next [3];
    rti_in_t              h_ray_reg;

    always_comb begin
        if (in_data.tneg) begin
            h_t_next    = '0;
            h_miss_next = in_data.miss || (in_q != '0) || in_data.sat || (epsilon != '0);
        end else begin
            h_t_next    = in_data.sat ? '1 : in_q;
            h_miss_next = in_data.miss || (h_t_next < epsilon);
        end
        h_p_next[0] = PW'(in_data.ray.direction_x) * PW'($signed({1'b0, h_t_next}));
        h_p_next[1] = PW'(in_data.ray.direction_y) * PW'($signed({1'b0, h_t_next}));
        h_p_next[2] = PW'(in_data.ray.direction_z) * PW'($signed({1'b0, h_t_next}));
    end

    logic     o_v_reg;
    rti_out_t o_reg;
    rti_out_t o_next;

    always_comb begin
        o_next = '0;
        if (!h_miss_reg) begin
            o_next.hit        = 1'b1;
            o_next.distance   = h_t_reg;
            o_next.hit_x      = hit_coord(h_p_reg[0], h_ray_reg.origin_x);
            o_next.hit_y      = hit_coord(h_p_reg[1], h_ray_reg.origin_y);
            o_next.hit_z      = hit_coord(h_p_reg[2], h_ray_reg.origin_z);
            o_next.surface_nx = vec_elem(normal, 0);
            o_next.surface_ny = vec_elem(normal, 1);
            o_next.surface_nz = vec_elem(normal, 2);
            o_next.hit_object = object_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end else if (en) begin
            h_v_reg <= in_valid;
            o_v_reg <= h_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_miss_reg <= h_miss_next;
            h_t_reg    <= h_t_next;
            h_p_reg    <= h_p_next;
            h_ray_reg  <= in_data.ray;
            o_reg      <= o_next;
        end
    end

    assign out_valid = o_v_reg;
    assign out_data  = o_reg;

endmodule

// ===== rtl/ray_triangle_intersect.sv =====
// top level of the ray/triangle intersection test with its configuration registers
//
// one triangle is held in configuration registers written through cfg_we,
// cfg_index and cfg_wdata; writes take effect at once and must be made while
// idle (the block does not enforce this); rays enter on s_valid/s_ready/s_data,
// one result per ray leaves on m_valid/m_ready/m_data; a miss returns hit low
// with all other fields zero; the pipeline has 7 front stages of products and
// sums, 20 divider stages (one quotient bit per stage) and 2 back stages ending
// in the result register
// throughput is one ray per cycle except in a stall; every stage advances together
// when the receiver stalls with a result waiting, the whole pipeline holds and
// s_ready drops in the same cycle; no transaction is lost or repeated
// during reset all valid bits clear and the configuration registers return
// to their defaults: epsilon 1, everything else 0
module ray_triangle_intersect import rti_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rti_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rti_out_t         m_data,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    logic [CFG_W-1:0] vertex0_reg;
    logic [CFG_W-1:0] edge1_reg;
    logic [CFG_W-1:0] edge2_reg;
    logic [CFG_W-1:0] normal_reg;
    logic [OBJ_W-1:0] object_id_reg;
    logic [CW-1:0]    epsilon_reg;
    logic             cull_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex0_reg   <= '0;
            edge1_reg     <= '0;
            edge2_reg     <= '0;
            normal_reg    <= '0;
            object_id_reg <= '0;
            epsilon_reg   <= CW'(1);
            cull_reg      <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_VERTEX0: vertex0_reg   <= cfg_wdata;
                REG_EDGE1:   edge1_reg     <= cfg_wdata;
                REG_EDGE2:   edge2_reg     <= cfg_wdata;
                REG_NORMAL:  normal_reg    <= cfg_wdata;
                REG_OBJECT:  object_id_reg <= cfg_wdata[OBJ_W-1:0];
                REG_EPSILON: epsilon_reg   <= cfg_wdata[CW-1:0];
                REG_CULL:    cull_reg      <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    logic       en;
    logic       front_valid;
    rti_front_t front_data;
    logic       div_valid;
    rti_front_t div_data;
    logic [CW-1:0] div_q;

    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    rti_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_ray   (s_data),
        .vertex0  (vertex0_reg),
        .edge1    (edge1_reg),
        .edge2    (edge2_reg),
        .epsilon  (epsilon_reg),
        .cull     (cull_reg),
        .out_valid(front_valid),
        .out_data (front_data)
    );

    rti_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (front_valid),
        .in_data  (front_data),
        .out_valid(div_valid),
        .out_data (div_data),
        .out_q    (div_q)
    );

    rti_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (div_valid),
        .in_data  (div_data),
        .in_q     (div_q),
        .epsilon  (epsilon_reg),
        .normal   (normal_reg),
        .object_id(object_id_reg),
        .out_valid(m_valid),
        .out_data (m_data)
    );

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.hit) |-> (m_data.distance == '0 && m_data.hit_x == '0 &&
                                      m_data.hit_object == '0))
        else $error("miss carries nonzero fields");

    a_hit_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.hit) |-> (m_data.distance >= epsilon_reg))
        else $error("hit closer than epsilon");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

// ===== tb/tb_ray_triangle_intersect.sv =====
// self-checking testbench for the ray/triangle intersection block
`timescale 1ns / 1ps

module tb_ray_triangle_intersect;
    import rti_pkg::*;

    typedef logic signed [127:0] wide_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    rti_in_t          s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    rti_out_t         m_data;
    logic             cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = REG_VERTEX0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    logic [CFG_W-1:0] tri_vertex0 = '0;
    logic [CFG_W-1:0] tri_edge1 = '0;
    logic [CFG_W-1:0] tri_edge2 = '0;
    logic [CFG_W-1:0] tri_normal = '0;
    logic [OBJ_W-1:0] tri_object = '0;
    logic [CW-1:0]    tri_epsilon = 1;
    logic             tri_cull = 1'b0;

    rti_out_t expected_hits[$];
    int       error_count = 0;
    int       hold_cycles = 0;
    bit       no_idle = 1'b0;

    ray_triangle_intersect dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #6 aclk = ~aclk;

    function automatic wide_t elem(input logic [CFG_W-1:0] p, input int k);
        coord_t c;
        c = coord_t'(p[k*CW +: CW]);
        return wide_t'(c);
    endfunction

    function automatic logic [CW-1:0] quotient_q(input wide_t n, input wide_t dv);
        wide_t q;
        q = (n <<< FB) / dv;
        if (q >= (wide_t'(1) <<< CW)) begin
            return {CW{1'b1}};
        end
        return q[CW-1:0];
    endfunction

    function automatic coord_t point_coord(input wide_t o, input wide_t d, input logic [CW-1:0] t);
        wide_t p, m, v, hi;
        p = d * $signed({108'b0, t});
        m = (p < 0 ? -p : p) >>> FB;
        v = o + (p < 0 ? -m : m);
        hi = (wide_t'(1) <<< (CW - 1)) - 1;
        if (v > hi) begin
            v = hi;
        end else if (v < -hi - 1) begin
            v = -hi - 1;
        end
        return coord_t'(v[CW-1:0]);
    endfunction

    function automatic rti_out_t predict_hit(input rti_in_t r);
        wide_t o[3], d[3], v0[3], e1[3], e2[3], pv[3], tv[3], qv[3];
        wide_t det, un, vn, tn, thr;
        logic [CW-1:0] t;
        rti_out_t res;
        res = '0;
        o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
        d[0] = r.direction_x; d[1] = r.direction_y; d[2] = r.direction_z;
        for (int k = 0; k < 3; k++) begin
            v0[k] = elem(tri_vertex0, k);
            e1[k] = elem(tri_edge1, k);
            e2[k] = elem(tri_edge2, k);
        end
        pv[0] = d[1]*e2[2] - d[2]*e2[1];
        pv[1] = d[2]*e2[0] - d[0]*e2[2];
        pv[2] = d[0]*e2[1] - d[1]*e2[0];
        det = e1[0]*pv[0] + e1[1]*pv[1] + e1[2]*pv[2];
        thr = $signed({108'b0, tri_epsilon}) <<< (2 * FB);
        if (det == 0) return res;
        if (tri_cull) begin
            if (det < thr) return res;
        end else begin
            if ((det < 0 ? -det : det) < thr) return res;
        end
        for (int k = 0; k < 3; k++) tv[k] = o[k] - v0[k];
        qv[0] = tv[1]*e1[2] - tv[2]*e1[1];
        qv[1] = tv[2]*e1[0] - tv[0]*e1[2];
        qv[2] = tv[0]*e1[1] - tv[1]*e1[0];
        un = tv[0]*pv[0] + tv[1]*pv[1] + tv[2]*pv[2];
        vn = d[0]*qv[0] + d[1]*qv[1] + d[2]*qv[2];
        tn = e2[0]*qv[0] + e2[1]*qv[1] + e2[2]*qv[2];
        if (det < 0) begin
            det = -det; un = -un; vn = -vn; tn = -tn;
        end
        if (un < 0 || un > det) return res;
        if (vn < 0 || un + vn > det) return res;
        if (tn < 0) begin
            if (quotient_q(-tn, det) != 0 || tri_epsilon != 0) return res;
            t = '0;
        end else begin
            t = quotient_q(tn, det);
            if (t < tri_epsilon) return res;
        end
        res.hit = 1'b1;
        res.distance = t;
        res.hit_x = point_coord(o[0], d[0], t);
        res.hit_y = point_coord(o[1], d[1], t);
        res.hit_z = point_coord(o[2], d[2], t);
        res.surface_nx = coord_t'(tri_normal[0 +: CW]);
        res.surface_ny = coord_t'(tri_normal[CW +: CW]);
        res.surface_nz = coord_t'(tri_normal[2*CW +: CW]);
        res.hit_object = tri_object;
        return res;
    endfunction

    function automatic logic [CFG_W-1:0] pack3(input int x, input int y, input int z);
        return {coord_t'(z), coord_t'(y), coord_t'(x)};
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_VERTEX0: tri_vertex0 = val;
            REG_EDGE1:   tri_edge1 = val;
            REG_EDGE2:   tri_edge2 = val;
            REG_NORMAL:  tri_normal = val;
            REG_OBJECT:  tri_object = val[OBJ_W-1:0];
            REG_EPSILON: tri_epsilon = val[CW-1:0];
            REG_CULL:    tri_cull = val[0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_hits.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_triangle(input logic [CFG_W-1:0] v0, input logic [CFG_W-1:0] e1,
                                input logic [CFG_W-1:0] e2, input logic [CW-1:0] eps,
                                input logic cull);
        drain();
        write_reg(REG_VERTEX0, v0);
        write_reg(REG_EDGE1, e1);
        write_reg(REG_EDGE2, e2);
        write_reg(REG_NORMAL, CFG_W'({$urandom, $urandom}));
        write_reg(REG_OBJECT, CFG_W'($urandom));
        write_reg(REG_EPSILON, CFG_W'(eps));
        write_reg(REG_CULL, CFG_W'(cull));
    endtask

    task automatic send_ray(input rti_in_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_hits.push_back(predict_hit(r));
    endtask

    task automatic send_xyz(input int ox, input int oy, input int oz,
                            input int dx, input int dy, input int dz);
        rti_in_t r;
        r.origin_x = coord_t'(ox); r.origin_y = coord_t'(oy); r.origin_z = coord_t'(oz);
        r.direction_x = coord_t'(dx); r.direction_y = coord_t'(dy);
        r.direction_z = coord_t'(dz);
        send_ray(r);
    endtask

    function automatic int rnd_coord(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // ray aimed at a point inside or outside the configured triangle
    task automatic send_aimed(input int span);
        int a, b, px[3], ox[3];
        rti_in_t r;
        a = $urandom_range(0, 1100);
        b = $urandom_range(0, 1100);
        for (int k = 0; k < 3; k++) begin
            px[k] = int'(elem(tri_vertex0, k)) + (a * int'(elem(tri_edge1, k))) / 1024
                    + (b * int'(elem(tri_edge2, k))) / 1024;
            ox[k] = px[k] + rnd_coord(span);
        end
        r.origin_x = coord_t'(ox[0]); r.origin_y = coord_t'(ox[1]);
        r.origin_z = coord_t'(ox[2]);
        r.direction_x = coord_t'(px[0] - ox[0]);
        r.direction_y = coord_t'(px[1] - ox[1]);
        r.direction_z = coord_t'(px[2] - ox[2]);
        if ($urandom_range(0, 3) == 0) begin
            r.direction_x = r.direction_x >>> 2;
            r.direction_y = r.direction_y >>> 2;
            r.direction_z = r.direction_z >>> 2;
        end
        send_ray(r);
    endtask

    task automatic random_triangle(input int span, input logic [CW-1:0] eps,
                                   input logic cull);
        set_triangle(pack3(rnd_coord(span), rnd_coord(span), rnd_coord(span)),
                     pack3(rnd_coord(span), rnd_coord(span), rnd_coord(span)),
                     pack3(rnd_coord(span), rnd_coord(span), rnd_coord(span)), eps, cull);
    endtask

    task automatic test_directed;
        set_triangle(pack3(0, 0, 0), pack3(1024, 0, 0), pack3(0, 1024, 0), 1, 1'b0);
        send_xyz(256, 256, 1024, 0, 0, -1024);
        send_xyz(0, 512, 1024, 0, 0, -1024);
        send_xyz(512, 512, 1024, 0, 0, -1024);
        send_xyz(600, 600, 1024, 0, 0, -1024);
        send_xyz(-1, 300, 1024, 0, 0, -1024);
        send_xyz(300, 300, 1024, 1024, 0, 0);
        send_xyz(256, 256, -1024, 0, 0, 1024);
        send_xyz(256, 256, -1024, 0, 0, -1024);
        send_xyz(256, 256, 0, 0, 0, -1024);
        send_xyz(256, 256, 1, 0, 0, -524288);
        send_xyz(256, 256, 524287, 0, 0, -1);
        send_xyz(524287, 524287, 524287, 524287, 524287, 524287);
        send_xyz(-524288, -524288, -524288, -524288, -524288, -524288);
        send_xyz(0, 0, 0, 0, 0, 0);
        set_triangle(pack3(0, 0, 0), pack3(1024, 0, 0), pack3(0, 1024, 0), 0, 1'b1);
        send_xyz(256, 256, 1024, 0, 0, -1024);
        send_xyz(256, 256, -1024, 0, 0, 1024);
        send_xyz(256, 256, -1, 0, 0, -524288);
        send_xyz(256, 256, 0, 0, 0, -1024);
        set_triangle({CFG_W{1'b1}}, pack3(524287, -524288, 524287),
                     pack3(-524288, 524287, -524288), {CW{1'b1}}, 1'b0);
        send_xyz(524287, -524288, 0, -524288, 524287, 524287);
        send_xyz(-524288, 524287, 1, 524287, -524288, -524288);
    endtask

    task automatic test_random_rays;
        int spans[4] = '{2048, 16384, 65536, 131071};
        for (int ph = 0; ph < 6; ph++) begin
            random_triangle(spans[ph % 4], CW'((ph == 2) ? 0 : $urandom_range(0, 64)),
                            ph[0]);
            no_idle = (ph == 3);
            for (int i = 0; i < 300; i++) begin
                if ($urandom_range(0, 9) < 7) begin
                    send_aimed(spans[ph % 4]);
                end else begin
                    send_ray(rti_in_t'((6*CW)'({$urandom, $urandom, $urandom, $urandom})));
                end
            end
            no_idle = 1'b0;
        end
    endtask

    task automatic test_backpressure;
        random_triangle(4096, 1, 1'b0);
        hold_cycles = 120;
        no_idle = 1'b1;
        for (int i = 0; i < 60; i++) send_aimed(4096);
        no_idle = 1'b0;
    endtask

    task automatic compare_field(input string name, input longint e, input longint a);
        if (e != a) begin
            $display("%0t: %s mismatch expected %0h actual %0h", $time, name, e, a);
            error_count++;
        end
    endtask

    initial begin : receiver
        rti_out_t e;
        int stall;
        wait (aresetn);
        forever begin
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 13);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (expected_hits.size() == 0) begin
                $display("%0t: unexpected transaction actual %0h", $time, m_data);
                error_count++;
            end else begin
                e = expected_hits.pop_front();
                compare_field("hit", e.hit, m_data.hit);
                compare_field("distance", e.distance, m_data.distance);
                compare_field("hit_x", e.hit_x, m_data.hit_x);
                compare_field("hit_y", e.hit_y, m_data.hit_y);
                compare_field("hit_z", e.hit_z, m_data.hit_z);
                compare_field("surface_nx", e.surface_nx, m_data.surface_nx);
                compare_field("surface_ny", e.surface_ny, m_data.surface_ny);
                compare_field("surface_nz", e.surface_nz, m_data.surface_nz);
                compare_field("hit_object", e.hit_object, m_data.hit_object);
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_backpressure();
        test_random_rays();
        drain();
        if (expected_hits.size() != 0 || error_count != 0) begin
            $display("tb_ray_triangle_intersect failed");
        end else begin
            $display("tb_ray_triangle_intersect passed");
        end
        $finish;
    end

    initial begin
        #(12 * 600000);
        $display("tb_ray_triangle_intersect failed");
        $finish;
    end

endmodule
